[rtl/pshc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshc_pkg
// Shared types and constants for the profile sample hash counter: field
// widths, item kind codes, result selection and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package pshc_pkg;

    localparam int MASK_W  = 45;
    localparam int COUNT_W = 32;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 8;

    // Item kinds. The fourth code carries no meaning and is ignored.
    typedef enum logic [KIND_W-1:0] {
        KIND_RECORD = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // What the result registers load when a result is produced.
    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_FULL   = 2'd1,
        RES_READ   = 2'd2,
        RES_UPDATE = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     hash_step;
        logic     probe_next;
        logic     sweep_wr;
        logic     upd_wr;
        logic     rd_idx;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ignore;
        logic              idx_ok;
        logic              hash_last;
        logic              probe_hit;
        logic              probe_last;
        logic              sweep_last;
    } ctrl_status_t;

endpackage

[rtl/pshc_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshc_dpath
// Datapath of the hash counter: item capture, serial modulo unit, probe
// pointer, slot memory, sweep counter and result registers.
// ----------------------------------------------------------------------------
module pshc_dpath #(
    parameter int TABLE_SIZE = 256,
    parameter int NUM_STAGES = 45
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pshc_pkg::KIND_W-1:0]       kind,
    input  logic [pshc_pkg::MASK_W-1:0]       stage_mask,
    input  logic                              suspended,
    input  logic [pshc_pkg::INDEX_W-1:0]      entry_index,
    input  pshc_pkg::ctrl_cmd_t               cmd,
    output pshc_pkg::ctrl_status_t            status,
    output logic [pshc_pkg::MASK_W-1:0]       entry_mask,
    output logic [pshc_pkg::COUNT_W-1:0]      entry_count,
    output logic                              table_full,
    output logic                              counted
);
    import pshc_pkg::*;

    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int AW_EXT      = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int HASH_STEP   = 5;
    localparam int HASH_CYCLES = (MASK_W + HASH_STEP - 1) / HASH_STEP;
    localparam int HASH_BITS   = HASH_STEP * HASH_CYCLES;
    localparam int HC_W        = $clog2(HASH_CYCLES);

    localparam logic [IDX_W:0]      DIVISOR   = (IDX_W + 1)'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0]    LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
    localparam logic [MASK_W-1:0]   STAGE_KEEP = (NUM_STAGES >= MASK_W) ?
        {MASK_W{1'b1}} : ((MASK_W'(1) << NUM_STAGES) - MASK_W'(1));

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
    } slot_t;

    slot_t mem [TABLE_SIZE];

    logic [KIND_W-1:0]    kind_reg;
    logic [MASK_W-1:0]    smask_reg;
    logic                 ignore_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 idx_ok_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [IDX_W-1:0]     probe_cnt_reg;
    logic [HASH_BITS-1:0] hash_sh_reg;
    logic [HC_W-1:0]      hash_cnt_reg;
    logic [IDX_W-1:0]     sweep_cnt_reg;
    slot_t                rd_data_reg;
    logic [MASK_W-1:0]    res_mask_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic                 res_full_reg;
    logic                 res_counted_reg;

    logic [MASK_W-1:0]    masked_in;
    logic [AW_EXT-1:0]    idx_ext;
    logic [IDX_W-1:0]     hash_rem;
    logic [IDX_W:0]       hash_trial;
    logic                 count_sat;
    logic [COUNT_W-1:0]   count_new;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    slot_t                wr_data;

    assign masked_in = stage_mask & STAGE_KEEP;
    assign idx_ext   = AW_EXT'(entry_index);

    // Restoring remainder, several bits per clock, most significant first.
    always_comb
    begin
        hash_rem   = slot_reg;
        hash_trial = '0;
        for (int j = 0; j < HASH_STEP; j++)
        begin
            hash_trial = {hash_rem, hash_sh_reg[HASH_BITS-1-j]};
            if (hash_trial >= DIVISOR)
            begin
                hash_trial = hash_trial - DIVISOR;
            end
            hash_rem = hash_trial[IDX_W-1:0];
        end
    end

    assign count_sat = (rd_data_reg.count == {COUNT_W{1'b1}});
    assign count_new = count_sat ? rd_data_reg.count : rd_data_reg.count + 1'b1;

    assign rd_addr = cmd.rd_idx ? idx_reg : slot_reg;
    assign wr_en   = cmd.sweep_wr | cmd.upd_wr;
    assign wr_addr = cmd.sweep_wr ? sweep_cnt_reg : slot_reg;

    always_comb
    begin
        if (cmd.sweep_wr)
        begin
            wr_data = '0;
        end
        else
        begin
            wr_data.mask  = smask_reg;
            wr_data.count = count_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Item fields, modulo unit and probe pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            smask_reg     <= masked_in;
            ignore_reg    <= suspended | (masked_in == '0);
            idx_reg       <= idx_ext[IDX_W-1:0];
            idx_ok_reg    <= ({1'b0, idx_ext} < (AW_EXT + 1)'(TABLE_SIZE));
            hash_sh_reg   <= HASH_BITS'(masked_in);
            hash_cnt_reg  <= '0;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_sh_reg  <= hash_sh_reg << HASH_STEP;
            hash_cnt_reg <= hash_cnt_reg + 1'b1;
            slot_reg     <= hash_rem;
        end
        else if (cmd.probe_next)
        begin
            slot_reg      <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_cnt_reg <= (sweep_cnt_reg == LAST_SLOT) ? '0 : sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_ZERO:
                begin
                    res_mask_reg    <= '0;
                    res_count_reg   <= '0;
                    res_full_reg    <= 1'b0;
                    res_counted_reg <= 1'b0;
                end
                RES_FULL:
                begin
                    res_mask_reg    <= '0;
                    res_count_reg   <= '0;
                    res_full_reg    <= 1'b1;
                    res_counted_reg <= 1'b0;
                end
                RES_READ:
                begin
                    res_mask_reg    <= rd_data_reg.mask;
                    res_count_reg   <= rd_data_reg.count;
                    res_full_reg    <= 1'b0;
                    res_counted_reg <= 1'b0;
                end
                RES_UPDATE:
                begin
                    res_mask_reg    <= smask_reg;
                    res_count_reg   <= count_new;
                    res_full_reg    <= 1'b0;
                    res_counted_reg <= ~count_sat;
                end
            endcase
        end
    end

    assign status.kind       = kind_reg;
    assign status.ignore     = ignore_reg;
    assign status.idx_ok     = idx_ok_reg;
    assign status.hash_last  = (hash_cnt_reg == HC_W'(HASH_CYCLES - 1));
    assign status.probe_hit  = (rd_data_reg.mask == smask_reg) || (rd_data_reg.mask == '0);
    assign status.probe_last = (probe_cnt_reg == LAST_SLOT);
    assign status.sweep_last = (sweep_cnt_reg == LAST_SLOT);

    assign entry_mask  = res_mask_reg;
    assign entry_count = res_count_reg;
    assign table_full  = res_full_reg;
    assign counted     = res_counted_reg;

endmodule

[rtl/pshc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshc_ctrl
// Controller of the hash counter: sequences the initial sweep, item decode,
// modulo steps, probing, reads, clears and the result strobe.
// ----------------------------------------------------------------------------
module pshc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pshc_pkg::ctrl_status_t status,
    output pshc_pkg::ctrl_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);
    import pshc_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_DISPATCH,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_READ_OUT,
        ST_CLEAR_SWEEP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.res_sel = RES_ZERO;

        unique case (state_reg)
            ST_INIT_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                    busy_next   = 1'b1;
                end
            end
            ST_DISPATCH:
            begin
                cmd.rd_idx = 1'b1;
                unique case (status.kind)
                    KIND_RECORD:
                    begin
                        if (status.ignore)
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            busy_next    = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_HASH;
                        end
                    end
                    KIND_READ:
                    begin
                        if (status.idx_ok)
                        begin
                            state_next = ST_READ_OUT;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            busy_next    = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        state_next = ST_CLEAR_SWEEP;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        done_next    = 1'b1;
                        busy_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (status.hash_last)
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                priority if (status.probe_hit)
                begin
                    cmd.upd_wr   = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_UPDATE;
                    done_next    = 1'b1;
                    busy_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
                else if (status.probe_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FULL;
                    done_next    = 1'b1;
                    busy_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_READ_OUT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_READ;
                done_next    = 1'b1;
                busy_next    = 1'b0;
                state_next   = ST_IDLE;
            end
            ST_CLEAR_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.res_load = 1'b1;
                    done_next    = 1'b1;
                    busy_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_SWEEP;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // The result strobe always coincides with the block becoming free.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // A result strobe lasts one cycle, since an item passes through idle and dispatch first.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // The sweep and the slot update never fight for the write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep_wr && cmd.upd_wr))
        else $error("memory write conflict");

    // Every slot update produces a result strobe in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.upd_wr |=> done_reg)
        else $error("slot update without a result");

endmodule

[rtl/profile_sample_hash_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_sample_hash_counter_core
// Sampling-profiler counting table with open addressing and linear probing.
// A record item stores a stage mask and counts it, a read item returns one
// slot, and a clear item empties the table.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------
//  item in   start & !busy      kind, stage_mask, suspended, entry_index
//  result    done (one cycle)   entry_mask, entry_count, table_full, counted
//
// Every accepted item produces exactly one result, strobed by done for one
// cycle; busy falls in the same cycle, so the next item can be taken at the
// following edge. A record item passes through a decode state, the serial
// modulo unit (five mask bits per clock) and then, for each slot probed (1 to
// TABLE_SIZE), a registered slot memory read followed by a check. An ignored
// sample, an out-of-range read or an unused kind ends in the decode state, a
// read adds a read-out state, and a clear runs the sweep that writes one slot
// per clock. After reset the same sweep clears the table with busy held high.
// The result receiver cannot stall, so there is no back-pressure path.
// ----------------------------------------------------------------------------
module profile_sample_hash_counter_core #(
    parameter int TABLE_SIZE = 256,
    parameter int NUM_STAGES = 45
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pshc_pkg::KIND_W-1:0]       kind,
    input  logic [pshc_pkg::MASK_W-1:0]       stage_mask,
    input  logic                              suspended,
    input  logic [pshc_pkg::INDEX_W-1:0]      entry_index,
    output logic                              done,
    output logic [pshc_pkg::MASK_W-1:0]       entry_mask,
    output logic [pshc_pkg::COUNT_W-1:0]      entry_count,
    output logic                              table_full,
    output logic                              counted
);
    import pshc_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // The controller owns the handshake: busy is high during the reset sweep
    // and from acceptance of an item until its result strobe.
    pshc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the captured item, the modulo unit that finds the
    // home slot, the probe pointer, the slot memory and the result registers.
    pshc_dpath #(
        .TABLE_SIZE (TABLE_SIZE),
        .NUM_STAGES (NUM_STAGES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .stage_mask  (stage_mask),
        .suspended   (suspended),
        .entry_index (entry_index),
        .cmd         (cmd),
        .status      (status),
        .entry_mask  (entry_mask),
        .entry_count (entry_count),
        .table_full  (table_full),
        .counted     (counted)
    );

endmodule
